/* rtl/point_distance_matrix_core_assert.svh */
// assertion macros for the distance matrix core
`ifndef POINT_DISTANCE_MATRIX_CORE_ASSERT_SVH
`define POINT_DISTANCE_MATRIX_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define PDMC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pdmc assertion failed");
`define PDMC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pdmc assertion failed");
`else
`define PDMC_ASSERT_NOW(lbl, ante, cons)
`define PDMC_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

/* rtl/pdm_pkg.sv */
`default_nettype none
package pdm_pkg;
  localparam int COORD_WIDTH    = 24;
  localparam int DIST_WIDTH     = 25;
  localparam int MAX_POINTS_DEF = 8;
  localparam int SLOT_W         = 3;
  localparam int PT_DEPTH       = 1 << SLOT_W;
  localparam int LEN_W          = 4;
  localparam int ADDR_W         = 2 * SLOT_W;
  localparam int STORE_DEPTH    = 1 << ADDR_W;
  localparam int MAG_W          = COORD_WIDTH + 1;
  localparam int SQ_W           = 2 * MAG_W;
  localparam int ACC_W          = SQ_W + 2;
  localparam int ROOT_STEPS     = (ACC_W + 1) / 2;
  localparam int OP_W           = 2 * ROOT_STEPS;
  localparam int ROOT_W         = ROOT_STEPS;
  localparam int REM_W          = ROOT_STEPS + 2;
  localparam int STEP_W         = $clog2(ROOT_STEPS + 1);
  localparam logic [DIST_WIDTH-1:0] DIST_MAX = {DIST_WIDTH{1'b1}};

  typedef enum logic [1:0] {
    MODE_LOAD_FIRST  = 2'd0,
    MODE_LOAD_SECOND = 2'd1,
    MODE_QUERY       = 2'd2,
    MODE_DUMP        = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_ROW   = 2'd2,
    STAT_COL   = 2'd3
  } status_t;

  typedef enum logic {
    REG_FIRST_LEN  = 1'b0,
    REG_SECOND_LEN = 1'b1
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DIFF, ST_MULT, ST_ACC, ST_ROOT, ST_STORE, ST_DECIDE, ST_READ, ST_SEND,
    ST_ERR
  } back_state_t;

  typedef struct packed {
    mode_t                         mode;
    logic [SLOT_W-1:0]             point_slot;
    logic signed [COORD_WIDTH-1:0] coord_x;
    logic signed [COORD_WIDTH-1:0] coord_y;
    logic signed [COORD_WIDTH-1:0] coord_z;
    logic [SLOT_W-1:0]             row_index;
    logic [SLOT_W-1:0]             column_index;
  } pdm_in_t;

  typedef struct packed {
    logic [DIST_WIDTH-1:0] distance;
    status_t               status;
    logic [DIST_WIDTH-1:0] min_distance;
    logic [DIST_WIDTH-1:0] max_distance;
    logic                  last;
  } pdm_out_t;

  typedef struct packed {
    logic              dump;
    logic [SLOT_W-1:0] row;
    logic [SLOT_W-1:0] col;
  } pdm_cmd_t;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] x;
    logic signed [COORD_WIDTH-1:0] y;
    logic signed [COORD_WIDTH-1:0] z;
  } pdm_point_t;

  typedef struct packed {
    pdm_point_t first;
    pdm_point_t second;
  } pdm_pair_t;

  typedef struct packed {
    logic     push;
    pdm_cmd_t cmd;
    logic     mark_stale;
  } pdm_front_ctl_t;
endpackage
`default_nettype wire

/* rtl/pdm_ram.sv */
`default_nettype none
module pdm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;
endmodule
`default_nettype wire

/* rtl/pdm_queue.sv */
`default_nettype none
module pdm_queue import pdm_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     push,
  input  wire pdm_cmd_t push_cmd,
  input  wire logic     pop,
  output pdm_cmd_t      head,
  output logic          empty,
  output logic          full
);
  pdm_cmd_t   entry_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = ~wr_ptr_r;
    end
    if (pop) begin
      rd_ptr_nxt = ~rd_ptr_r;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

  assign head  = entry_r[rd_ptr_r];
  assign empty = (cnt_r == 2'd0);
  assign full  = (cnt_r == 2'd2);
endmodule
`default_nettype wire

/* rtl/pdm_front.sv */
`default_nettype none
module pdm_front import pdm_pkg::*; #(
  parameter int MAX_POINTS = MAX_POINTS_DEF
) (
  input  wire logic              clk,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire pdm_in_t           in_data,
  input  wire logic              q_empty,
  input  wire logic              q_full,
  input  wire logic              back_busy,
  input  wire logic [SLOT_W-1:0] rd_first,
  input  wire logic [SLOT_W-1:0] rd_second,
  output pdm_pair_t              pair,
  output pdm_front_ctl_t         ctl
);
  pdm_point_t first_r  [PT_DEPTH];
  pdm_point_t second_r [PT_DEPTH];
  pdm_point_t pt;
  logic       is_load;
  logic       slot_ok;
  logic       accept;

  assign is_load = (in_data.mode == MODE_LOAD_FIRST) || (in_data.mode == MODE_LOAD_SECOND);
  assign slot_ok = ({1'b0, in_data.point_slot} < (SLOT_W+1)'(MAX_POINTS));
  assign in_stall = is_load ? (!q_empty || back_busy) : q_full;
  assign accept   = in_valid && !in_stall;

  assign pt.x = in_data.coord_x;
  assign pt.y = in_data.coord_y;
  assign pt.z = in_data.coord_z;

  always_ff @(posedge clk) begin
    if (accept && slot_ok) begin
      if (in_data.mode == MODE_LOAD_FIRST) begin
        first_r[in_data.point_slot] <= pt;
      end else if (in_data.mode == MODE_LOAD_SECOND) begin
        second_r[in_data.point_slot] <= pt;
      end
    end
  end

  assign pair.first  = first_r[rd_first];
  assign pair.second = second_r[rd_second];

  assign ctl.push       = accept && !is_load;
  assign ctl.cmd.dump   = (in_data.mode == MODE_DUMP);
  assign ctl.cmd.row    = in_data.row_index;
  assign ctl.cmd.col    = in_data.column_index;
  assign ctl.mark_stale = accept && is_load && slot_ok;
endmodule
`default_nettype wire

/* rtl/pdm_back.sv */
`default_nettype none
module pdm_back import pdm_pkg::*; #(
  parameter int MAX_POINTS = MAX_POINTS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_we,
  input  wire logic [0:0]        cfg_index,
  input  wire logic [LEN_W-1:0]  cfg_data,
  input  wire logic              mark_stale,
  input  wire logic              q_empty,
  input  wire pdm_cmd_t          q_head,
  output logic                   q_pop,
  output logic [SLOT_W-1:0]      rd_first,
  output logic [SLOT_W-1:0]      rd_second,
  input  wire pdm_pair_t         pair,
  output logic                   busy,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output pdm_out_t               out_data
);
  back_state_t state_r, state_nxt;
  logic [LEN_W-1:0]      len1_r, len1_nxt, len2_r, len2_nxt;
  logic                  stale_r, stale_nxt;
  logic [DIST_WIDTH-1:0] min_r, min_nxt, max_r, max_nxt;
  pdm_cmd_t              cmd_r, cmd_nxt;
  logic [SLOT_W-1:0]     i_r, i_nxt, j_r, j_nxt;
  logic [1:0]            ax_r, ax_nxt;
  logic [MAG_W-1:0]      mag_r, mag_nxt;
  logic [SQ_W-1:0]       sq_r, sq_nxt;
  logic [ACC_W-1:0]      acc_r, acc_nxt;
  logic                  clamp_r, clamp_nxt;
  logic [OP_W-1:0]       op_r, op_nxt;
  logic [REM_W-1:0]      rem_r, rem_nxt;
  logic [ROOT_W-1:0]     root_r, root_nxt;
  logic [STEP_W-1:0]     step_r, step_nxt;
  status_t               err_r, err_nxt;
  logic                  out_valid_r, out_valid_nxt;
  pdm_out_t              out_r, out_nxt;

  logic [LEN_W-1:0]      cfg_len;
  logic signed [MAG_W-1:0] ca, cb, diff;
  logic [MAG_W-1:0]      mag_abs;
  logic [REM_W-1:0]      rem_sh, trial;
  logic [DIST_WIDTH-1:0] dist_val;
  logic                  ram_we;
  logic [ADDR_W-1:0]     raddr;
  logic [DIST_WIDTH-1:0] rdata;
  logic                  out_free;
  logic                  end_i, end_j, lists_empty;

  pdm_ram #(.WIDTH(DIST_WIDTH), .DEPTH(STORE_DEPTH)) u_dist_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr ({i_r, j_r}),
    .wdata (dist_val),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign cfg_len = (cfg_data > LEN_W'(MAX_POINTS)) ? LEN_W'(MAX_POINTS) : cfg_data;
  assign rd_first  = i_r;
  assign rd_second = j_r;
  assign raddr     = cmd_r.dump ? {i_r, j_r} : {cmd_r.row, cmd_r.col};
  assign out_free  = !out_valid_r || !out_stall;
  assign end_i     = ({1'b0, i_r} + 1'b1 == len1_r);
  assign end_j     = ({1'b0, j_r} + 1'b1 == len2_r);
  assign lists_empty = (len1_r == '0) || (len2_r == '0);

  always_comb begin
    case (ax_r)
      2'd0: begin
        ca = {pair.first.x[COORD_WIDTH-1], pair.first.x};
        cb = {pair.second.x[COORD_WIDTH-1], pair.second.x};
      end
      2'd1: begin
        ca = {pair.first.y[COORD_WIDTH-1], pair.first.y};
        cb = {pair.second.y[COORD_WIDTH-1], pair.second.y};
      end
      default: begin
        ca = {pair.first.z[COORD_WIDTH-1], pair.first.z};
        cb = {pair.second.z[COORD_WIDTH-1], pair.second.z};
      end
    endcase
    diff    = ca - cb;
    mag_abs = diff[MAG_W-1] ? MAG_W'(-diff) : MAG_W'(diff);
    rem_sh  = {rem_r[REM_W-3:0], op_r[OP_W-1 -: 2]};
    trial   = {root_r, 2'b01};
    if (clamp_r || (root_r > ROOT_W'(DIST_MAX))) begin
      dist_val = DIST_MAX;
    end else begin
      dist_val = root_r[DIST_WIDTH-1:0];
    end
  end

  always_comb begin
    state_nxt     = state_r;
    len1_nxt      = len1_r;
    len2_nxt      = len2_r;
    stale_nxt     = stale_r;
    min_nxt       = min_r;
    max_nxt       = max_r;
    cmd_nxt       = cmd_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    ax_nxt        = ax_r;
    mag_nxt       = mag_r;
    sq_nxt        = sq_r;
    acc_nxt       = acc_r;
    clamp_nxt     = clamp_r;
    op_nxt        = op_r;
    rem_nxt       = rem_r;
    root_nxt      = root_r;
    step_nxt      = step_r;
    err_nxt       = err_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_nxt       = out_r;
    q_pop         = 1'b0;
    ram_we        = 1'b0;

    if (cfg_we) begin
      stale_nxt = 1'b1;
      if (cfg_index == REG_FIRST_LEN) begin
        len1_nxt = cfg_len;
      end else begin
        len2_nxt = cfg_len;
      end
    end
    if (mark_stale) begin
      stale_nxt = 1'b1;
    end

    case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          q_pop   = 1'b1;
          cmd_nxt = q_head;
          if (stale_r) begin
            stale_nxt = 1'b0;
            min_nxt   = DIST_MAX;
            max_nxt   = '0;
            i_nxt     = '0;
            j_nxt     = '0;
            ax_nxt    = '0;
            acc_nxt   = '0;
            clamp_nxt = 1'b0;
            state_nxt = lists_empty ? ST_DECIDE : ST_DIFF;
          end else begin
            state_nxt = ST_DECIDE;
          end
        end
      end
      ST_DIFF: begin
        mag_nxt   = mag_abs;
        clamp_nxt = clamp_r || (mag_abs > MAG_W'(DIST_MAX));
        state_nxt = ST_MULT;
      end
      ST_MULT: begin
        sq_nxt    = mag_r * mag_r;
        state_nxt = ST_ACC;
      end
      ST_ACC: begin
        acc_nxt = acc_r + ACC_W'(sq_r);
        if (ax_r == 2'd2) begin
          ax_nxt    = '0;
          op_nxt    = OP_W'(acc_r + ACC_W'(sq_r));
          rem_nxt   = '0;
          root_nxt  = '0;
          step_nxt  = '0;
          state_nxt = ST_ROOT;
        end else begin
          ax_nxt    = ax_r + 2'd1;
          state_nxt = ST_DIFF;
        end
      end
      ST_ROOT: begin
        op_nxt = {op_r[OP_W-3:0], 2'b00};
        if (rem_sh >= trial) begin
          rem_nxt  = rem_sh - trial;
          root_nxt = {root_r[ROOT_W-2:0], 1'b1};
        end else begin
          rem_nxt  = rem_sh;
          root_nxt = {root_r[ROOT_W-2:0], 1'b0};
        end
        step_nxt = step_r + 1'b1;
        if (step_r == STEP_W'(ROOT_STEPS - 1)) begin
          state_nxt = ST_STORE;
        end
      end
      ST_STORE: begin
        ram_we = 1'b1;
        if (dist_val > max_r) begin
          max_nxt = dist_val;
        end
        if (dist_val < min_r) begin
          min_nxt = dist_val;
        end
        acc_nxt   = '0;
        clamp_nxt = 1'b0;
        state_nxt = ST_DIFF;
        if (end_j) begin
          j_nxt = '0;
          if (end_i) begin
            i_nxt     = '0;
            state_nxt = ST_DECIDE;
          end else begin
            i_nxt = i_r + 1'b1;
          end
        end else begin
          j_nxt = j_r + 1'b1;
        end
      end
      ST_DECIDE: begin
        i_nxt = '0;
        j_nxt = '0;
        if (lists_empty) begin
          err_nxt   = STAT_EMPTY;
          state_nxt = ST_ERR;
        end else if (!cmd_r.dump && ({1'b0, cmd_r.row} >= len1_r)) begin
          err_nxt   = STAT_ROW;
          state_nxt = ST_ERR;
        end else if (!cmd_r.dump && ({1'b0, cmd_r.col} >= len2_r)) begin
          err_nxt   = STAT_COL;
          state_nxt = ST_ERR;
        end else begin
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        state_nxt = ST_SEND;
      end
      ST_SEND: begin
        if (out_free) begin
          out_valid_nxt        = 1'b1;
          out_nxt.distance     = rdata;
          out_nxt.status       = STAT_OK;
          out_nxt.min_distance = min_r;
          out_nxt.max_distance = max_r;
          out_nxt.last         = !cmd_r.dump || (end_i && end_j);
          if (!cmd_r.dump || (end_i && end_j)) begin
            state_nxt = ST_IDLE;
          end else begin
            state_nxt = ST_READ;
            if (end_j) begin
              j_nxt = '0;
              i_nxt = i_r + 1'b1;
            end else begin
              j_nxt = j_r + 1'b1;
            end
          end
        end
      end
      ST_ERR: begin
        if (out_free) begin
          out_valid_nxt        = 1'b1;
          out_nxt.distance     = '0;
          out_nxt.status       = err_r;
          out_nxt.min_distance = min_r;
          out_nxt.max_distance = max_r;
          out_nxt.last         = 1'b1;
          state_nxt            = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      len1_r      <= '0;
      len2_r      <= '0;
      stale_r     <= 1'b1;
      min_r       <= DIST_MAX;
      max_r       <= '0;
      i_r         <= '0;
      j_r         <= '0;
      ax_r        <= '0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      len1_r      <= len1_nxt;
      len2_r      <= len2_nxt;
      stale_r     <= stale_nxt;
      min_r       <= min_nxt;
      max_r       <= max_nxt;
      i_r         <= i_nxt;
      j_r         <= j_nxt;
      ax_r        <= ax_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r   <= cmd_nxt;
    mag_r   <= mag_nxt;
    sq_r    <= sq_nxt;
    acc_r   <= acc_nxt;
    clamp_r <= clamp_nxt;
    op_r    <= op_nxt;
    rem_r   <= rem_nxt;
    root_r  <= root_nxt;
    err_r   <= err_nxt;
    out_r   <= out_nxt;
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
endmodule
`default_nettype wire

/* rtl/point_distance_matrix_core.sv */
// channel  direction  handshake             beat
// in_      input      in_valid / in_stall   pdm_in_t: load point, query or dump
// out_     output     out_valid / out_stall pdm_out_t: one distance with min, max, last
// cfg_     input      cfg_we                list length write, index 0 or 1
//
// a recompute of a stale matrix runs, per pair, three subtract, square and add passes
// (ST_DIFF, ST_MULT, ST_ACC), the one-bit-per-cycle root (ST_ROOT) and one store
// after any recompute, a query passes ST_DECIDE, ST_READ and ST_SEND; a dump alternates
// ST_READ and ST_SEND per beat, bound by the registered read of the distance ram
// reset is synchronous; point and distance stores hold no reset value
// a load waits while any query or dump is queued or in work; the queue holds two
`default_nettype none
`include "point_distance_matrix_core_assert.svh"
module point_distance_matrix_core import pdm_pkg::*; #(
  parameter int MAX_POINTS = MAX_POINTS_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire pdm_in_t          in_data,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output pdm_out_t              out_data,
  input  wire logic             cfg_we,
  input  wire logic [0:0]       cfg_index,
  input  wire logic [LEN_W-1:0] cfg_data
);
  pdm_front_ctl_t    ctl;
  pdm_pair_t         pair;
  pdm_cmd_t          q_head;
  logic              q_empty, q_full, q_pop;
  logic              back_busy;
  logic [SLOT_W-1:0] rd_first, rd_second;

  pdm_front #(.MAX_POINTS(MAX_POINTS)) u_front (
    .clk       (clk),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .q_empty   (q_empty),
    .q_full    (q_full),
    .back_busy (back_busy),
    .rd_first  (rd_first),
    .rd_second (rd_second),
    .pair      (pair),
    .ctl       (ctl)
  );

  pdm_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (ctl.push),
    .push_cmd (ctl.cmd),
    .pop      (q_pop),
    .head     (q_head),
    .empty    (q_empty),
    .full     (q_full)
  );

  pdm_back #(.MAX_POINTS(MAX_POINTS)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .mark_stale (ctl.mark_stale),
    .q_empty    (q_empty),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .rd_first   (rd_first),
    .rd_second  (rd_second),
    .pair       (pair),
    .busy       (back_busy),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

  `PDMC_ASSERT_NOW(a_load_when_idle, ctl.mark_stale, q_empty && !back_busy)
  `PDMC_ASSERT_NOW(a_error_is_last, out_valid && (out_data.status != STAT_OK), out_data.last)
  `PDMC_ASSERT_NEXT(a_pop_starts_work, q_pop, back_busy)
endmodule
`default_nettype wire

/* tb/point_distance_matrix_core_tb.sv */
`default_nettype none
module point_distance_matrix_core_tb;
  import pdm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 40000;
  localparam int IDLE_SETTLE    = 2600;
  localparam longint unsigned DMASK = 64'h1FF_FFFF;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  pdm_in_t          in_data = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  pdm_out_t         out_data;
  logic             cfg_we = 1'b0;
  logic [0:0]       cfg_index = '0;
  logic [LEN_W-1:0] cfg_data = '0;

  point_distance_matrix_core DUT (.*);

  always #5 clk = ~clk;

  longint          first_pt[8][3];
  longint          second_pt[8][3];
  longint unsigned dist_mem[64];
  longint unsigned min_seen = DMASK;
  longint unsigned max_seen = 0;
  bit              stale = 1'b1;
  int unsigned     len_first = 0;
  int unsigned     len_second = 0;

  pdm_out_t    expected_beats[$];
  int          mismatches = 0;
  int          items_sent = 0;
  int          beats_seen = 0;
  int          queries_sent = 0;
  int          dumps_sent = 0;
  bit          quiet = 1'b0;
  int          stall_left = 0;
  int          idle_cycles = 0;

  function automatic longint unsigned isqrt(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint unsigned pair_dist(int i, int j);
    longint unsigned sum, r, d;
    sum = 0;
    for (int k = 0; k < 3; k++) begin
      longint diff;
      diff = first_pt[i][k] - second_pt[j][k];
      d = (diff < 0) ? longint'(-diff) : longint'(diff);
      if (d > DMASK) return DMASK;
      sum += d * d;
    end
    r = isqrt(sum);
    return (r > DMASK) ? DMASK : r;
  endfunction

  function automatic void rebuild_matrix();
    longint unsigned d;
    min_seen = DMASK;
    max_seen = 0;
    stale = 1'b0;
    if (len_first == 0 || len_second == 0) return;
    for (int i = 0; i < len_first; i++) begin
      for (int j = 0; j < len_second; j++) begin
        d = pair_dist(i, j);
        dist_mem[i * 8 + j] = d;
        if (d > max_seen) max_seen = d;
        if (d < min_seen) min_seen = d;
      end
    end
  endfunction

  function automatic void push_beat(longint unsigned d, status_t st, bit lst);
    pdm_out_t e;
    e.distance     = d[DIST_WIDTH-1:0];
    e.status       = st;
    e.min_distance = min_seen[DIST_WIDTH-1:0];
    e.max_distance = max_seen[DIST_WIDTH-1:0];
    e.last         = lst;
    expected_beats.push_back(e);
  endfunction

  function automatic longint sx(logic [COORD_WIDTH-1:0] v);
    return {{(64-COORD_WIDTH){v[COORD_WIDTH-1]}}, v};
  endfunction

  function automatic void predict_matrix(pdm_in_t b);
    int s;
    s = b.point_slot;
    if (b.mode == MODE_LOAD_FIRST || b.mode == MODE_LOAD_SECOND) begin
      if (b.mode == MODE_LOAD_FIRST) begin
        first_pt[s][0] = sx(b.coord_x);
        first_pt[s][1] = sx(b.coord_y);
        first_pt[s][2] = sx(b.coord_z);
      end else begin
        second_pt[s][0] = sx(b.coord_x);
        second_pt[s][1] = sx(b.coord_y);
        second_pt[s][2] = sx(b.coord_z);
      end
      stale = 1'b1;
      return;
    end
    if (stale) rebuild_matrix();
    if (len_first == 0 || len_second == 0) begin
      push_beat(0, STAT_EMPTY, 1'b1);
    end else if (b.mode == MODE_QUERY) begin
      if (b.row_index >= len_first) push_beat(0, STAT_ROW, 1'b1);
      else if (b.column_index >= len_second) push_beat(0, STAT_COL, 1'b1);
      else push_beat(dist_mem[b.row_index * 8 + b.column_index], STAT_OK, 1'b1);
    end else begin
      for (int i = 0; i < len_first; i++)
        for (int j = 0; j < len_second; j++)
          push_beat(dist_mem[i * 8 + j], STAT_OK,
                    (i + 1 == len_first) && (j + 1 == len_second));
    end
  endfunction

  task automatic send_beat(input pdm_in_t b);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= b;
    do @(posedge clk); while (in_stall);
    predict_matrix(b);
    items_sent++;
    if (b.mode == MODE_QUERY) queries_sent++;
    if (b.mode == MODE_DUMP) dumps_sent++;
  endtask

  task automatic write_length(input reg_idx_t idx, input int unsigned val);
    int unsigned v;
    in_valid <= 1'b0;
    wait (expected_beats.size() == 0);
    repeat (IDLE_SETTLE) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val[LEN_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    v = (val & 15) > 8 ? 8 : (val & 15);
    if (idx == REG_FIRST_LEN) len_first = v;
    else len_second = v;
    stale = 1'b1;
  endtask

  function automatic pdm_in_t make_load(mode_t m, int slot, logic [23:0] x, logic [23:0] y,
                                        logic [23:0] z);
    pdm_in_t b;
    b = '0;
    b.mode = m;
    b.point_slot = slot[SLOT_W-1:0];
    b.coord_x = x;
    b.coord_y = y;
    b.coord_z = z;
    return b;
  endfunction

  function automatic pdm_in_t make_ask(mode_t m, int row, int col);
    pdm_in_t b;
    b = '0;
    b.mode = m;
    b.row_index = row[SLOT_W-1:0];
    b.column_index = col[SLOT_W-1:0];
    return b;
  endfunction

  function automatic logic [23:0] rand_coord();
    int unsigned sel;
    sel = $urandom_range(0, 3);
    if (sel == 0) return 24'h800000;
    if (sel == 1) return 24'($urandom);
    return 24'($urandom_range(0, 4000)) - 24'd2000;
  endfunction

  task automatic test_empty_lists();
    send_beat(make_ask(MODE_QUERY, 0, 0));
    send_beat(make_ask(MODE_DUMP, 7, 7));
  endtask

  task automatic test_extreme_points();
    for (int s = 0; s < 8; s++) begin
      send_beat(make_load(MODE_LOAD_FIRST, s, (s[0] ? 24'h7FFFFF : 24'h800000),
                          (s[1] ? 24'h800000 : 24'h7FFFFF), 24'(s * 256)));
      send_beat(make_load(MODE_LOAD_SECOND, s, (s[0] ? 24'h800000 : 24'h7FFFFF),
                          (s[2] ? 24'h7FFFFF : 24'h800000), 24'h000000));
    end
    write_length(REG_FIRST_LEN, 8);
    write_length(REG_SECOND_LEN, 8);
    send_beat(make_ask(MODE_DUMP, 0, 0));
    send_beat(make_ask(MODE_QUERY, 7, 7));
  endtask

  task automatic test_range_errors();
    write_length(REG_FIRST_LEN, 3);
    write_length(REG_SECOND_LEN, 15);
    write_length(REG_SECOND_LEN, 5);
    send_beat(make_ask(MODE_QUERY, 5, 6));
    send_beat(make_ask(MODE_QUERY, 1, 7));
    send_beat(make_ask(MODE_QUERY, 2, 4));
    write_length(REG_SECOND_LEN, 0);
    send_beat(make_ask(MODE_QUERY, 0, 0));
  endtask

  task automatic test_random_traffic();
    int phase;
    int burst;
    int unsigned pick;
    phase = 0;
    while (items_sent < 360) begin
      quiet = (phase % 4 == 3);
      pick = $urandom_range(0, 9);
      write_length(REG_FIRST_LEN, pick == 0 ? $urandom_range(0, 15) :
                   (pick == 1 ? 0 : $urandom_range(1, 3)));
      pick = $urandom_range(0, 9);
      write_length(REG_SECOND_LEN, pick == 0 ? $urandom_range(0, 15) :
                   (pick == 1 ? 0 : $urandom_range(1, 3)));
      burst = $urandom_range(10, 30);
      repeat (burst) begin
        pick = $urandom_range(0, 19);
        if (pick < 10)
          send_beat(make_load(pick[0] ? MODE_LOAD_SECOND : MODE_LOAD_FIRST,
                              $urandom_range(0, 7), rand_coord(), rand_coord(), rand_coord()));
        else if (pick < 17)
          send_beat(make_ask(MODE_QUERY, $urandom_range(0, 7), $urandom_range(0, 7)));
        else
          send_beat(make_ask(MODE_DUMP, $urandom_range(0, 7), $urandom_range(0, 7)));
      end
      phase++;
    end
    quiet = 1'b0;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      pdm_out_t e;
      beats_seen++;
      if (expected_beats.size() == 0) begin
        $error("unexpected result beat %p", out_data);
        mismatches++;
      end else begin
        e = expected_beats.pop_front();
        if (out_data.distance !== e.distance) begin
          $error("distance expected %0d got %0d", e.distance, out_data.distance);
          mismatches++;
        end
        if (out_data.status !== e.status) begin
          $error("status expected %0d got %0d", e.status, out_data.status);
          mismatches++;
        end
        if (out_data.min_distance !== e.min_distance) begin
          $error("min_distance expected %0d got %0d", e.min_distance, out_data.min_distance);
          mismatches++;
        end
        if (out_data.max_distance !== e.max_distance) begin
          $error("max_distance expected %0d got %0d", e.max_distance, out_data.max_distance);
          mismatches++;
        end
        if (out_data.last !== e.last) begin
          $error("last expected %0d got %0d", e.last, out_data.last);
          mismatches++;
        end
      end
      stall_left = quiet ? 0 : $urandom_range(0, 17);
    end
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    test_empty_lists();
    test_extreme_points();
    test_range_errors();
    test_random_traffic();
    in_valid <= 1'b0;
    wait (expected_beats.size() == 0);
    repeat (100) @(posedge clk);
    $display("sent %0d items (%0d queries, %0d dumps), checked %0d result beats",
             items_sent, queries_sent, dumps_sent, beats_seen);
    $display("lengths covered 0 to 8 with saturating writes, coordinates at both extremes");
    if (mismatches == 0 && expected_beats.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
`default_nettype wire
